### design/stepper_steering_position_control_assert.svh
// Assertion macros used by the steering controller checker.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef STEPPER_STEERING_POSITION_CONTROL_ASSERT_SVH
`define STEPPER_STEERING_POSITION_CONTROL_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SSPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SSPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked at every edge, reset included
`define SSPC_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/sspc_pkg.sv
// Shared types and constants for the stepper steering position controller.
// No dependencies.
package sspc_pkg;

  // Field widths
  localparam int ADC_W    = 12;
  localparam int REQ_W    = 8;
  localparam int PCT_W    = 7;
  localparam int DB_W     = 7;
  localparam int LIMIT_W  = 16;
  localparam int COUNT_W  = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Percent scale and its saturation value
  localparam int unsigned PCT_SCALE = 100;
  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(PCT_SCALE);
  localparam logic [PCT_W-1:0] PCT_MID = 7'd50;

  // Scaled product adc * 100 stays below 2^PROD_BITS
  localparam int PROD_BITS = 19;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADBAND       = 2'd0,
    CFG_MAX_HALF_STEPS = 2'd1
  } cfg_idx_t;

  // Item kinds
  typedef enum logic {
    FUNC_TICK   = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  // Reset values of the configuration registers
  localparam logic [DB_W-1:0]    DEADBAND_RST = 7'd3;
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = 16'd1000;

endpackage

### design/sspc_if.sv
// Valid/ready channel interfaces for the steering controller: input items,
// result items and configuration writes. Depends on sspc_pkg.
interface sspc_in_if import sspc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [ADC_W-1:0]         adc_sample;
  logic signed [REQ_W-1:0]  steer_request;

  modport source (output valid, output func, output adc_sample, output steer_request,
                  input ready);
  modport sink   (input valid, input func, input adc_sample, input steer_request,
                  output ready);
endinterface

interface sspc_out_if import sspc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      pulse_level;
  logic                      direction_left;
  logic                      step_enable;
  logic [PCT_W-1:0]          position_percent;
  logic signed [COUNT_W-1:0] step_count;

  modport source (output valid, output pulse_level, output direction_left,
                  output step_enable, output position_percent, output step_count,
                  input ready);
  modport sink   (input valid, input pulse_level, input direction_left,
                  input step_enable, input position_percent, input step_count,
                  output ready);
endinterface

interface sspc_cfg_if import sspc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/stepper_steering_position_control.sv
// Stepper steering position controller: bang-bang with deadband and stall limit.
// Path from an accepted item to result valid: input register, scaling
// register, state/result register. Throughput: one item per cycle; every
// stage advances whenever the next one can take its item.
// Reset (rst_n low, synchronous): pipeline empty, position 50, count 0,
// stepping off, direction right, pulse low, deadband 3, limit 1000.
module stepper_steering_position_control
  import sspc_pkg::*;
#(
  parameter int unsigned ADC_FULL_SCALE = 4095
) (
  input  logic      clk,
  input  logic      rst_n,
  sspc_in_if.sink   in_ch,
  sspc_out_if.source out_ch,
  sspc_cfg_if.sink  cfg_ch
);

  // Exact division by ADC_FULL_SCALE through a rounded-up reciprocal
  localparam int SCALE_LOG = $clog2(ADC_FULL_SCALE);
  localparam int SHIFT     = PROD_BITS + SCALE_LOG;
  localparam longint unsigned MAGIC =
    ((64'd1 << SHIFT) + 64'(ADC_FULL_SCALE) - 64'd1) / 64'(ADC_FULL_SCALE);
  localparam longint unsigned SCALE_K = MAGIC * 64'(PCT_SCALE);
  localparam int K_W    = $clog2(SCALE_K + 64'd1);
  localparam int PROD_W = ADC_W + K_W;

  // Configuration registers
  logic [DB_W-1:0]    deadband_r;
  logic [LIMIT_W-1:0] limit_r;

  // Pipeline stage 1: raw item
  logic                    s1_v_r;
  logic                    s1_func_r;
  logic [ADC_W-1:0]        s1_adc_r;
  logic signed [REQ_W-1:0] s1_req_r;

  // Pipeline stage 2: scaled item
  logic                    s2_v_r;
  logic                    s2_func_r;
  logic [PCT_W-1:0]        s2_pct_r;
  logic signed [REQ_W-1:0] s2_req_r;

  // Controller state
  logic [PCT_W-1:0]          pos_r, pos_nxt;
  logic [PCT_W-1:0]          prog_r, prog_nxt;
  logic signed [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic                      step_r, step_nxt;
  logic                      left_r, left_nxt;
  logic                      pulse_r, pulse_nxt;

  // Result register
  logic                      out_v_r;
  logic                      out_pulse_r;
  logic                      out_left_r;
  logic                      out_step_r;
  logic [PCT_W-1:0]          out_pos_r;
  logic signed [COUNT_W-1:0] out_cnt_r;

  // Flow control
  logic out_adv, s2_adv, s1_adv, in_acc;
  assign out_adv = !out_v_r || out_ch.ready;
  assign s2_adv  = s2_v_r && out_adv;
  assign s1_adv  = s1_v_r && (!s2_v_r || out_adv);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !s1_v_r || s1_adv;
  assign cfg_ch.ready = 1'b1;

  // Scale the reading to percent and saturate
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] quo;
  logic [PCT_W-1:0]  pct;
  always_comb begin
    prod = PROD_W'(s1_adc_r) * PROD_W'(SCALE_K);
    quo  = prod >> SHIFT;
    pct  = (quo > PROD_W'(PCT_SCALE)) ? PCT_MAX : quo[PCT_W-1:0];
  end

  // Sample and tick update of the controller state
  logic signed [REQ_W:0]   err;
  logic [REQ_W:0]          err_mag;
  logic                    over_db;
  logic signed [COUNT_W:0] cnt_ext;
  logic signed [COUNT_W:0] lim_ext;
  logic                    room;
  logic                    progress;
  logic signed [COUNT_W-1:0] cnt_base;
  always_comb begin
    pos_nxt   = pos_r;
    prog_nxt  = prog_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    left_nxt  = left_r;
    pulse_nxt = pulse_r;
    err       = (REQ_W+1)'(s2_req_r) - $signed({2'b00, s2_pct_r});
    err_mag   = err[REQ_W] ? (REQ_W+1)'(-err) : err;
    over_db   = err_mag > (REQ_W+1)'(deadband_r);
    cnt_ext   = (COUNT_W+1)'(cnt_r);
    lim_ext   = $signed({2'b00, limit_r});
    room      = left_r ? ((-cnt_ext) < lim_ext) : (cnt_ext < lim_ext);
    progress  = left_r ? (pos_r < prog_r) : (pos_r > prog_r);
    cnt_base  = progress ? '0 : cnt_r;
    if (s2_func_r == FUNC_SAMPLE) begin
      pos_nxt = s2_pct_r;
      if (over_db && (err < 0)) begin
        step_nxt = 1'b1;
        left_nxt = 1'b1;
      end else if (over_db && (err > 0)) begin
        step_nxt = 1'b1;
        left_nxt = 1'b0;
      end else begin
        step_nxt = 1'b0;
      end
    end else if (!step_r) begin
      pulse_nxt = 1'b0;
    end else if (room) begin
      pulse_nxt = !pulse_r;
      if (progress) begin
        prog_nxt = pos_r;
      end
      cnt_nxt = left_r ? (cnt_base - COUNT_W'(1)) : (cnt_base + COUNT_W'(1));
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      deadband_r <= DEADBAND_RST;
      limit_r    <= LIMIT_RST;
      pos_r      <= PCT_MID;
      prog_r     <= PCT_MID;
      cnt_r      <= '0;
      step_r     <= 1'b0;
      left_r     <= 1'b0;
      pulse_r    <= 1'b0;
    end else begin
      // Advance pipeline valids
      if (in_ch.ready) begin
        s1_v_r <= in_acc;
      end
      if (!s2_v_r || out_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
      // Commit item to the controller state
      if (s2_adv) begin
        pos_r   <= pos_nxt;
        prog_r  <= prog_nxt;
        cnt_r   <= cnt_nxt;
        step_r  <= step_nxt;
        left_r  <= left_nxt;
        pulse_r <= pulse_nxt;
      end
      // Take configuration writes; ignore unknown indexes
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_DEADBAND:       deadband_r <= cfg_ch.data[DB_W-1:0];
          CFG_MAX_HALF_STEPS: limit_r    <= cfg_ch.data[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_ch.func;
      s1_adc_r  <= in_ch.adc_sample;
      s1_req_r  <= in_ch.steer_request;
    end
    if (s1_adv) begin
      s2_func_r <= s1_func_r;
      s2_pct_r  <= pct;
      s2_req_r  <= s1_req_r;
    end
    if (s2_adv) begin
      out_pulse_r <= pulse_nxt;
      out_left_r  <= left_nxt;
      out_step_r  <= step_nxt;
      out_pos_r   <= pos_nxt;
      out_cnt_r   <= cnt_nxt;
    end
  end

  // Drive the result channel
  assign out_ch.valid            = out_v_r;
  assign out_ch.pulse_level      = out_pulse_r;
  assign out_ch.direction_left   = out_left_r;
  assign out_ch.step_enable      = out_step_r;
  assign out_ch.position_percent = out_pos_r;
  assign out_ch.step_count       = out_cnt_r;

endmodule

### design/sspc_checker.sv
// Port-level checker for the steering controller, bound to the top level.
// Depends on sspc_pkg and stepper_steering_position_control_assert.svh.
`include "stepper_steering_position_control_assert.svh"

module sspc_checker
  import sspc_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      pulse_level,
  input logic                      direction_left,
  input logic                      step_enable,
  input logic [PCT_W-1:0]          position_percent,
  input logic signed [COUNT_W-1:0] step_count
);

  // Position never leaves the percent range
  `SSPC_ASSERT_NOW(a_pos_range, clk, rst_n, out_valid, position_percent <= PCT_MAX, "position above 100 percent")

  // Stall limit keeps the count off the most negative code
  `SSPC_ASSERT_NOW(a_count_range, clk, rst_n, out_valid, step_count != {1'b1, {(COUNT_W-1){1'b0}}}, "step count out of range")

  // Pipeline is empty right after reset
  `SSPC_ASSERT_ALWAYS(a_reset_empty, clk, $past(!rst_n), !out_valid, "result valid right after reset")

  // Stalled item holds its payload
  `SSPC_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pulse_level) && $stable(direction_left) && $stable(step_enable) && $stable(position_percent) && $stable(step_count), "stalled item changed")

endmodule

bind stepper_steering_position_control sspc_checker u_sspc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .pulse_level      (out_ch.pulse_level),
  .direction_left   (out_ch.direction_left),
  .step_enable      (out_ch.step_enable),
  .position_percent (out_ch.position_percent),
  .step_count       (out_ch.step_count)
);
